>>> src/circle_vertex_generator_core_defines.svh
// ---------------------------------------------------------------------------
// circle vertex generator assertion macros
// shared concurrent assertion forms, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef CIRCLE_VERTEX_GENERATOR_CORE_DEFINES_SVH
`define CIRCLE_VERTEX_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define CVG_ASSERT_IMPL(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("cvg assertion failed");

// next-cycle implication
`define CVG_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("cvg assertion failed");

`else

`define CVG_ASSERT_IMPL(label, clk, rst, cond, prop)
`define CVG_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

>>> src/cvg_pkg.sv
// ---------------------------------------------------------------------------
// cvg_pkg
// shared types, constants and the rotation coefficient table builder
// ---------------------------------------------------------------------------
package cvg_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int FRAC_BITS    = 16;
  localparam int TRIG_BITS    = 30;
  localparam int PI_NUM       = 31415;
  localparam int PI_DEN       = 10000;
  localparam int TAYLOR_ORDER = 14;

  localparam int COORD_W = 32;
  localparam int DIAM_W  = 31;
  localparam int COUNT_W = 7;
  localparam int INDEX_W = 6;
  localparam int COEF_W  = FRAC_BITS + 2;
  localparam int ROM_AW  = $clog2(MAX_VERTICES);

  // queue depth must stay a power of two, pointers wrap naturally
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic        [DIAM_W-1:0]  diameter;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic        [COUNT_W-1:0] vertex_count;
  } req_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic        [INDEX_W-1:0] vertex_index;
    logic                      last_vertex;
  } vtx_word_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] rot_cos;
    logic signed [COEF_W-1:0] rot_sin;
  } coef_pair_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic        [COUNT_W-1:0] count;
    coef_pair_t                coef;
  } job_t;

  // shift-subtract divide, elaboration use only
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // q30 product, rounded to nearest on the magnitude
  function automatic longint qmul(input longint a, input longint b);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned p;
    logic            neg;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? longint'(-a) : longint'(a);
    mb  = (b < 0) ? longint'(-b) : longint'(b);
    p   = (ma * mb + (64'd1 << (TRIG_BITS - 1))) >> TRIG_BITS;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  // divide truncating toward zero
  function automatic longint sdiv(input longint a, input longint unsigned k);
    longint unsigned m;
    longint unsigned q;
    m = (a < 0) ? longint'(-a) : longint'(a);
    q = udiv(m, k);
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  // round q30 to coefficient precision and saturate
  function automatic logic signed [COEF_W-1:0] to_coef(input longint v);
    longint r;
    longint hi;
    longint lo;
    r  = (v + (64'sd1 <<< (TRIG_BITS - FRAC_BITS - 1))) >>> (TRIG_BITS - FRAC_BITS);
    hi = (64'sd1 <<< (COEF_W - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (r > hi) begin
      r = hi;
    end else if (r < lo) begin
      r = lo;
    end
    return COEF_W'(r);
  endfunction

  // cos and sin of 2*pi/n: taylor series on an eighth of the angle,
  // then three angle doublings
  function automatic coef_pair_t rom_entry(input int unsigned n);
    longint unsigned num;
    longint unsigned den;
    longint          alpha;
    longint          term;
    longint          c;
    longint          s;
    longint          nc;
    longint          ns;
    coef_pair_t      res;
    num   = (64'd2 * 64'(PI_NUM)) << TRIG_BITS;
    den   = 64'(PI_DEN) * 64'd8 * 64'(n);
    alpha = longint'(udiv(num + (den >> 1), den));
    term  = 64'sd1 <<< TRIG_BITS;
    c     = term;
    s     = 0;
    for (int k = 1; k <= TAYLOR_ORDER; k++) begin
      term = sdiv(qmul(term, alpha), 64'(k));
      unique case (k % 4)
        0:       c = c + term;
        1:       s = s + term;
        2:       c = c - term;
        default: s = s - term;
      endcase
    end
    for (int k = 0; k < 3; k++) begin
      nc = qmul(c, c) - qmul(s, s);
      ns = 2 * qmul(s, c);
      c  = nc;
      s  = ns;
    end
    res.rot_cos = to_coef(c);
    res.rot_sin = to_coef(s);
    return res;
  endfunction

endpackage

>>> src/cvg_queue.sv
// ---------------------------------------------------------------------------
// cvg_queue
// small job queue between request front end and vertex engine
// ---------------------------------------------------------------------------
`include "circle_vertex_generator_core_defines.svh"

module cvg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  cvg_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output cvg_pkg::job_t pop_job
);

  cvg_pkg::job_t                 entries [cvg_pkg::QUEUE_DEPTH];
  logic [cvg_pkg::QPTR_W-1:0]    wr_ptr;
  logic [cvg_pkg::QPTR_W-1:0]    rd_ptr;
  logic [cvg_pkg::QPTR_W:0]      count;
  logic                          push_fire;
  logic                          pop_fire;

  assign push_ready = (count != (cvg_pkg::QPTR_W + 1)'(cvg_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_job;
    end
  end

  `CVG_ASSERT_IMPL(a_ptr_match, clk, rst, (count == '0 || count == (cvg_pkg::QPTR_W + 1)'(cvg_pkg::QUEUE_DEPTH)), (wr_ptr == rd_ptr))
  `CVG_ASSERT_NEXT(a_push_lands, clk, rst, (push_fire && !pop_fire), (count == $past(count) + 1'b1))

endmodule

>>> src/cvg_front.sv
// ---------------------------------------------------------------------------
// cvg_front
// request intake: clamps the count, drops empty requests, fetches coefficients
// ---------------------------------------------------------------------------
`include "circle_vertex_generator_core_defines.svh"

module cvg_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  cvg_pkg::req_word_t req,
  output logic               push_valid,
  input  logic               push_ready,
  output cvg_pkg::job_t      push_job
);

  cvg_pkg::coef_pair_t             coef_tab [cvg_pkg::MAX_VERTICES];
  logic [cvg_pkg::COUNT_W-1:0]     n_clamp;
  logic [cvg_pkg::ROM_AW-1:0]      rom_addr;
  logic                            req_fire;
  logic                            slot_valid;
  cvg_pkg::job_t                   slot;

  // coefficient table, entry g holds the step for g+1 vertices
  for (genvar g = 0; g < cvg_pkg::MAX_VERTICES; g++) begin : g_tab
    localparam cvg_pkg::coef_pair_t ENTRY = cvg_pkg::rom_entry(g + 1);
    assign coef_tab[g] = ENTRY;
  end

  assign n_clamp = (req.vertex_count > cvg_pkg::COUNT_W'(cvg_pkg::MAX_VERTICES)) ?
                   cvg_pkg::COUNT_W'(cvg_pkg::MAX_VERTICES) : req.vertex_count;
  assign rom_addr = cvg_pkg::ROM_AW'(n_clamp - 1'b1);

  assign req_ready  = !slot_valid || push_ready;
  assign req_fire   = req_valid && req_ready;
  assign push_valid = slot_valid;
  assign push_job   = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (req_fire && (n_clamp != '0)) begin
      slot_valid <= 1'b1;
    end else if (push_ready) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      slot.start_x  <= cvg_pkg::COORD_W'(req.diameter >> 1);
      slot.center_x <= req.center_x;
      slot.center_y <= req.center_y;
      slot.count    <= n_clamp;
      slot.coef     <= coef_tab[rom_addr];
    end
  end

  `CVG_ASSERT_IMPL(a_slot_count, clk, rst, slot_valid, (slot.count != '0 && slot.count <= cvg_pkg::COUNT_W'(cvg_pkg::MAX_VERTICES)))

endmodule

>>> src/cvg_engine.sv
// ---------------------------------------------------------------------------
// cvg_engine
// vertex engine: emits one vertex, then rotates the offset for the next
// ---------------------------------------------------------------------------
`include "circle_vertex_generator_core_defines.svh"

module cvg_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  output logic               job_ready,
  input  cvg_pkg::job_t      job,
  output logic               vtx_valid,
  input  logic               vtx_ready,
  output cvg_pkg::vtx_word_t vtx
);

  localparam int PROD_W = cvg_pkg::COEF_W + cvg_pkg::COORD_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CW     = cvg_pkg::COORD_W;

  localparam logic signed [SUM_W-1:0] COORD_HI =
    {{(SUM_W - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] COORD_LO =
    {{(SUM_W - CW + 1){1'b1}}, {(CW - 1){1'b0}}};
  localparam logic signed [SUM_W-1:0] ROUND_HALF =
    SUM_W'(64'sd1 <<< (cvg_pkg::FRAC_BITS - 1));

  typedef enum logic [1:0] {ST_IDLE, ST_EMIT, ST_ROTATE} state_t;

  state_t                          state;
  cvg_pkg::job_t                   cur;
  logic signed [CW-1:0]            off_x;
  logic signed [CW-1:0]            off_y;
  logic [cvg_pkg::INDEX_W-1:0]     idx;
  logic [cvg_pkg::COUNT_W-1:0]     left;
  logic signed [PROD_W-1:0]        prod_cx;
  logic signed [PROD_W-1:0]        prod_sy;
  logic signed [PROD_W-1:0]        prod_sx;
  logic signed [PROD_W-1:0]        prod_cy;
  logic signed [SUM_W-1:0]         rnd_x;
  logic signed [SUM_W-1:0]         rnd_y;
  logic signed [CW-1:0]            rot_x;
  logic signed [CW-1:0]            rot_y;
  logic signed [CW:0]              sum_px;
  logic signed [CW:0]              sum_py;
  logic                            emit_go;

  function automatic logic signed [CW-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    priority if (v > COORD_HI) begin
      return CW'(COORD_HI);
    end else if (v < COORD_LO) begin
      return CW'(COORD_LO);
    end else begin
      return CW'(v);
    end
  endfunction

  assign job_ready = (state == ST_IDLE);
  assign emit_go   = !vtx_valid || vtx_ready;

  // vertex position from center plus offset
  assign sum_px = (CW + 1)'(cur.center_x) + (CW + 1)'(off_x);
  assign sum_py = (CW + 1)'(cur.center_y) + (CW + 1)'(off_y);

  // rotation from registered products, round half up
  assign rnd_x = SUM_W'(prod_cx) - SUM_W'(prod_sy) + ROUND_HALF;
  assign rnd_y = SUM_W'(prod_sx) + SUM_W'(prod_cy) + ROUND_HALF;
  assign rot_x = sat_coord(rnd_x >>> cvg_pkg::FRAC_BITS);
  assign rot_y = sat_coord(rnd_y >>> cvg_pkg::FRAC_BITS);

  always_ff @(posedge clk) begin
    prod_cx <= cur.coef.rot_cos * off_x;
    prod_sy <= cur.coef.rot_sin * off_y;
    prod_sx <= cur.coef.rot_sin * off_x;
    prod_cy <= cur.coef.rot_cos * off_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vtx_valid <= 1'b0;
      idx       <= '0;
      left      <= '0;
    end else begin
      // a taken word drops valid unless the emit state reloads it
      if (vtx_valid && vtx_ready && (state != ST_EMIT)) begin
        vtx_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            off_x <= job.start_x;
            off_y <= '0;
            idx   <= '0;
            left  <= job.count;
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            vtx_valid        <= 1'b1;
            vtx.point_x      <= sat_coord(SUM_W'(sum_px));
            vtx.point_y      <= sat_coord(SUM_W'(sum_py));
            vtx.vertex_index <= idx;
            vtx.last_vertex  <= (left == cvg_pkg::COUNT_W'(1));
            idx              <= idx + 1'b1;
            left             <= left - 1'b1;
            state            <= (left == cvg_pkg::COUNT_W'(1)) ? ST_IDLE : ST_ROTATE;
          end
        end
        ST_ROTATE: begin
          off_x <= rot_x;
          off_y <= rot_y;
          state <= ST_EMIT;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CVG_ASSERT_IMPL(a_count_track, clk, rst, (state != ST_IDLE), ((cvg_pkg::COUNT_W'(idx) + left) == cur.count))
  `CVG_ASSERT_IMPL(a_rotate_pending, clk, rst, (state == ST_ROTATE), (left != '0))
  `CVG_ASSERT_NEXT(a_last_ends_run, clk, rst, (state == ST_EMIT && emit_go && left == cvg_pkg::COUNT_W'(1)), (state == ST_IDLE && vtx_valid && vtx.last_vertex))

endmodule

>>> src/circle_vertex_generator_core.sv
// path: the first vertex word of a request passes the front-end slot, the queue write,
//   the engine load and the output register before it is valid
// flow: each vertex takes an emit state and, but for the last, a rotate state that turns
//   the offset; the engine picks up the next job only from its idle state
// the front end takes new requests while the engine runs: 2 jobs queue, 1 waits in front
// reset: synchronous, active high; clears all valids, the queue and the engine state
// ---------------------------------------------------------------------------
// circle_vertex_generator_core
// polygon vertices around a circle by repeated rotation of the offset
// ---------------------------------------------------------------------------
module circle_vertex_generator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  cvg_pkg::req_word_t req,
  output logic               vtx_valid,
  input  logic               vtx_ready,
  output cvg_pkg::vtx_word_t vtx
);

  // front end to queue
  logic          fq_valid;
  logic          fq_ready;
  cvg_pkg::job_t fq_job;

  // queue to engine
  logic          qe_valid;
  logic          qe_ready;
  cvg_pkg::job_t qe_job;

  // front end: clamps the vertex count to the table size, swallows requests
  // with no vertices, and looks up cos/sin of the step angle in a constant table
  cvg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job)
  );

  // decouples intake from the engine so either side can stall alone
  cvg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qe_valid),
    .pop_ready  (qe_ready),
    .pop_job    (qe_job)
  );

  // engine: first offset is half the diameter on x, each later offset is
  // the previous one rotated, rounded and saturated; vertex words leave
  // through a registered output stage
  cvg_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .job_valid (qe_valid),
    .job_ready (qe_ready),
    .job       (qe_job),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .vtx       (vtx)
  );

endmodule

>>> verif/circle_vertex_generator_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// circle_vertex_generator_core_tb
// self-checking bench: circle requests in, rotated polygon vertices out,
// every vertex compared against a bit-exact fixed-point rotation predictor
// ---------------------------------------------------------------------------
module circle_vertex_generator_core_tb;

  import cvg_pkg::*;

  // slowest plausible run: ~400 requests of up to 64 vertices, each vertex
  // paying an emit and a rotate state plus a sparse receiver, plus long holds and gaps,
  // lands well under a quarter of this
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_REQS   = 352;
  localparam int LONG_HOLD_LEN = 400;
  localparam int SETTLE_CYCLES = 64;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_MOSTLY
  } ready_mode_t;

  // one request word plus a flag that makes the sender wait for an empty pipe
  typedef struct packed {
    logic      drain_first;
    req_word_t word;
  } pending_req_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_word_t req       = '0;
  logic      vtx_valid;
  logic      vtx_ready = 1'b0;
  vtx_word_t vtx;

  pending_req_t requests_pending[$];
  vtx_word_t    vertices_due[$];

  // bookkeeping, all of it testbench-side
  int mismatches         = 0;
  int vertices_checked   = 0;
  int reqs_taken         = 0;
  int zero_count_reqs    = 0;
  int capped_count_reqs  = 0;
  int saturated_points   = 0;
  int input_stall_cycles = 0;
  int drain_pauses       = 0;
  int long_holds         = 0;
  int cycles             = 0;

  // sender burst shaping
  int burst_left = 8;
  int gap_left   = 0;

  // receiver pacing
  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left  = 0;
  int          hold_left  = 0;

  circle_vertex_generator_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .vtx_valid (vtx_valid),
    .vtx_ready (vtx_ready),
    .vtx       (vtx)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // fixed-point helpers for the predictor
  // ---------------------------------------------------------------------------

  // q30 product, rounded to nearest on the magnitude, sign applied after
  function automatic longint q30_mul(input longint a, input longint b);
    longint unsigned ma;
    longint unsigned mb;
    longint unsigned p;
    ma = (a < 0) ? longint'(-a) : a;
    mb = (b < 0) ? longint'(-b) : b;
    p  = (ma * mb + (64'd1 << (TRIG_BITS - 1))) >> TRIG_BITS;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  // add half an lsb then floor
  function automatic longint round_half_up(input longint v, input int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic longint saturate(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // predictor: every vertex one accepted request should produce, in order
  // ---------------------------------------------------------------------------
  task automatic predict_circle(input req_word_t w);
    longint unsigned num;
    longint unsigned den;
    longint          alpha;
    longint          term;
    longint          cos_q;
    longint          sin_q;
    longint          nc;
    longint          ns;
    longint          ox;
    longint          oy;
    longint          nx;
    longint          ny;
    longint          cx;
    longint          cy;
    longint          px;
    longint          py;
    int              n;
    vtx_word_t       v;
    n = int'(w.vertex_count);
    // counts above the table size clamp to the largest polygon
    if (n > MAX_VERTICES) begin
      n = MAX_VERTICES;
      capped_count_reqs++;
    end
    // zero count: nothing comes out
    if (n == 0) begin
      zero_count_reqs++;
      return;
    end

    // coefficients of 2*pi/n: taylor series on an eighth of the angle
    num   = (64'd2 * 64'(PI_NUM)) << TRIG_BITS;
    den   = 64'(PI_DEN) * 64'd8 * 64'(n);
    alpha = longint'((num + den / 2) / den);
    term  = 64'sd1 <<< TRIG_BITS;
    cos_q = term;
    sin_q = 0;
    for (int k = 1; k <= TAYLOR_ORDER; k++) begin
      // signed divide truncates toward zero
      term = q30_mul(term, alpha) / longint'(k);
      case (k % 4)
        0:       cos_q = cos_q + term;
        1:       sin_q = sin_q + term;
        2:       cos_q = cos_q - term;
        default: sin_q = sin_q - term;
      endcase
    end
    // three angle doublings bring the eighth back to the full step
    for (int k = 0; k < 3; k++) begin
      nc    = q30_mul(cos_q, cos_q) - q30_mul(sin_q, sin_q);
      ns    = 2 * q30_mul(sin_q, cos_q);
      cos_q = nc;
      sin_q = ns;
    end
    cos_q = saturate(round_half_up(cos_q, TRIG_BITS - FRAC_BITS), COEF_W);
    sin_q = saturate(round_half_up(sin_q, TRIG_BITS - FRAC_BITS), COEF_W);

    // first offset is half the diameter, floored, on the x axis
    ox = longint'(w.diameter >> 1);
    oy = 0;
    cx = longint'(w.center_x);
    cy = longint'(w.center_y);
    for (int i = 0; i < n; i++) begin
      px = saturate(cx + ox, COORD_W);
      py = saturate(cy + oy, COORD_W);
      if (px != cx + ox || py != cy + oy) begin
        saturated_points++;
      end
      v.point_x      = px[COORD_W-1:0];
      v.point_y      = py[COORD_W-1:0];
      v.vertex_index = INDEX_W'(i);
      v.last_vertex  = (i == n - 1);
      vertices_due.push_back(v);
      // exact rotation, then round to q16 and clamp
      nx = cos_q * ox - sin_q * oy;
      ny = sin_q * ox + cos_q * oy;
      ox = saturate(round_half_up(nx, FRAC_BITS), COORD_W);
      oy = saturate(round_half_up(ny, FRAC_BITS), COORD_W);
    end
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns mismatch: %s", $time, what);
  endtask

  task automatic add_req(input logic [DIAM_W-1:0] diam, input logic [COORD_W-1:0] cx,
                         input logic [COORD_W-1:0] cy, input logic [COUNT_W-1:0] cnt,
                         input logic drain);
    pending_req_t p;
    p.drain_first       = drain;
    p.word.diameter     = diam;
    p.word.center_x     = cx;
    p.word.center_y     = cy;
    p.word.vertex_count = cnt;
    requests_pending.push_back(p);
  endtask

  // centers: half full range, the other half the rails and small values
  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: bursts of words with random gaps, held until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    pending_req_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
      req       <= '0;
    end else begin
      // a taken word is predicted right away, before its first vertex can come out
      if (req_valid && req_ready) begin
        predict_circle(req);
        reqs_taken++;
      end
      if (req_valid && !req_ready) begin
        // word stays up, payload untouched
        input_stall_cycles++;
      end else if (gap_left != 0) begin
        gap_left--;
        req_valid <= 1'b0;
      end else if (requests_pending.size() == 0 ||
                   (requests_pending[0].drain_first && vertices_due.size() != 0)) begin
        // nothing left, or holding a drain point until every vertex is back
        req_valid <= 1'b0;
      end else begin
        nxt = requests_pending.pop_front();
        if (nxt.drain_first) begin
          drain_pauses++;
        end
        req       <= nxt.word;
        req_valid <= 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          // a third of the bursts run straight into the next one
          case ($urandom_range(0, 5))
            0, 1:    gap_left = 0;
            2:       gap_left = $urandom_range(10, 30);
            default: gap_left = $urandom_range(1, 6);
          endcase
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // vertex receiver pacing: a mode per stretch, plus two long holds that back
  // the block all the way up to its request port
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : pace_receiver
    if (rst) begin
      vtx_ready <= 1'b0;
    end else begin
      if (hold_left == 0 && long_holds < 2 && reqs_taken >= (long_holds == 0 ? 30 : 220)) begin
        hold_left = LONG_HOLD_LEN;
        long_holds++;
      end
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        vtx_ready <= 1'b0;
      end else begin
        case (ready_mode)
          READY_ALWAYS: vtx_ready <= 1'b1;
          READY_HALF:   vtx_ready <= ($urandom_range(0, 1) == 1);
          READY_SPARSE: vtx_ready <= ($urandom_range(0, 3) == 0);
          default:      vtx_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // vertex monitor: each taken word against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_vertices
    vtx_word_t want;
    if (!rst && vtx_valid && vtx_ready) begin
      if (vertices_due.size() == 0) begin
        report_mismatch($sformatf("unexpected vertex x=%h y=%h index %0d last %b",
                                  vtx.point_x, vtx.point_y, vtx.vertex_index,
                                  vtx.last_vertex));
      end else begin
        want = vertices_due.pop_front();
        if (vtx.point_x !== want.point_x) begin
          report_mismatch($sformatf("vertex %0d point_x %h, predicted %h",
                                    vertices_checked, vtx.point_x, want.point_x));
        end
        if (vtx.point_y !== want.point_y) begin
          report_mismatch($sformatf("vertex %0d point_y %h, predicted %h",
                                    vertices_checked, vtx.point_y, want.point_y));
        end
        if (vtx.vertex_index !== want.vertex_index) begin
          report_mismatch($sformatf("vertex %0d vertex_index %0d, predicted %0d",
                                    vertices_checked, vtx.vertex_index,
                                    want.vertex_index));
        end
        if (vtx.last_vertex !== want.last_vertex) begin
          report_mismatch($sformatf("vertex %0d last_vertex %b, predicted %b",
                                    vertices_checked, vtx.last_vertex,
                                    want.last_vertex));
        end
      end
      vertices_checked++;
    end
  end

  // watchdog
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d vertices still owed",
               cycles, vertices_due.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int                 made;
    int                 pick;
    int                 total_reqs;
    logic [DIAM_W-1:0]  diam;
    logic [COUNT_W-1:0] cnt;

    // directed: small known shapes
    add_req(31'h0002_0000, 32'h0000_0000, 32'h0000_0000, 7'd4, 1'b0);  // radius 1.0 square
    add_req(31'h0010_0000, 32'h0001_0000, 32'hFFFF_0000, 7'd1, 1'b0);  // single vertex, last at 0
    add_req(31'h0010_0000, 32'hFFF0_0000, 32'h0008_0000, 7'd2, 1'b0);
    add_req(31'h0010_0000, 32'h0000_8000, 32'h0000_0000, 7'd3, 1'b0);
    add_req(31'h0000_0003, 32'h0000_0000, 32'h0000_0000, 7'd5, 1'b0);  // odd diameter floors
    add_req(31'h0000_0000, 32'h1234_5678, 32'hEDCB_A988, 7'd6, 1'b0);  // zero diameter
    // saturation toward both rails on both axes
    add_req(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 7'd4, 1'b0);
    add_req(31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 7'd4, 1'b0);
    add_req(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 7'd3, 1'b0);
    add_req(31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 7'd2, 1'b0);
    add_req(31'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 7'd64, 1'b0); // full polygon, big radius
    // zero counts back to back, then counts above the cap
    add_req(31'h0064_0000, 32'h0000_0000, 32'h0000_0000, 7'd0, 1'b0);
    add_req(31'h0064_0000, 32'h0100_0000, 32'h0000_0000, 7'd0, 1'b0);
    add_req(31'h0020_0000, 32'h0000_0000, 32'hFF00_0000, 7'd65, 1'b0);
    add_req(31'h0020_0000, 32'h00FF_0000, 32'h0000_0000, 7'd127, 1'b0);
    // alternating bit patterns
    add_req(31'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 7'b0101010, 1'b0);
    add_req(31'h2AAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 7'b1010101, 1'b0);
    // let the pipe empty once before the random part
    add_req(31'h0008_0000, 32'h0000_0000, 32'h0000_0000, 7'd8, 1'b1);

    // random: mostly small polygons, some full, some capped, a few empty
    made = 0;
    while (made < RANDOM_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        cnt = 7'd0;
      end else if (pick < 60) begin
        cnt = COUNT_W'($urandom_range(1, 16));
      end else if (pick < 88) begin
        cnt = COUNT_W'($urandom_range(17, MAX_VERTICES));
      end else begin
        cnt = COUNT_W'($urandom_range(MAX_VERTICES + 1, 127));
      end
      case ($urandom_range(0, 3))
        0:       diam = DIAM_W'($urandom);
        1:       diam = DIAM_W'($urandom_range(0, 32'h0010_0000));
        2:       diam = DIAM_W'(32'h7FFF_FFFF - $urandom_range(0, 4095));
        default: diam = DIAM_W'($urandom) >> $urandom_range(0, 30);
      endcase
      add_req(diam, pick_coord(), pick_coord(), cnt, (made % 90) == 45);
      made++;
    end
    total_reqs = requests_pending.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // every word taken, then every vertex back, then a quiet stretch
    while (reqs_taken < total_reqs) @(posedge clk);
    while (vertices_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests (%0d empty, %0d above the vertex cap), %0d vertices checked",
             reqs_taken, zero_count_reqs, capped_count_reqs, vertices_checked);
    $display("%0d clamped points, request port held off %0d cycles, %0d long holds, %0d drains",
             saturated_points, input_stall_cycles, long_holds, drain_pauses);
    if (mismatches == 0 && vertices_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/cvg_pkg.sv
src/cvg_queue.sv
src/cvg_front.sv
src/cvg_engine.sv
src/circle_vertex_generator_core.sv
verif/circle_vertex_generator_core_tb.sv
